[sv/mst_pkg.sv]
// types, codes and sizes shared by the multi-slot software timer
package mst_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int MIN_SCALE = 1;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 4;
  localparam int SCALE_W   = 16;
  localparam int DATA_W    = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10;

  // command kinds
  localparam logic [1:0] KIND_ARM    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // response codes
  localparam logic EVENT_STATUS   = 1'b0;
  localparam logic EVENT_FIRE     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] period;
    logic              periodic;
    logic [DATA_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic              event_res;
    logic              status;
    logic [SLOT_W-1:0] fired_slot;
    logic [DATA_W-1:0] fired_tag;
    logic [DATA_W-1:0] epoch;
    logic              last;
  } rsp_t;

endpackage

[sv/multi_slot_software_timer_core.sv]
// multi-slot software timer: slot store, prescaler and expiry scan
// arm or cancel: the status word is held, then moved to the response register once that is free
// a tick that closes a scale step scans NUM_SLOTS slots at one per cycle through the
// slot memory read port, unless a second expiry waits on a held one and a stalled output
// a tick that does not close a step only advances the prescaler; one command word at a time
// reset (rst, synchronous) frees all slots, clears prescaler and epoch, scale to 10
module multi_slot_software_timer_core
  import mst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command words
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  // response words
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  // scale register write
  input  logic               scale_we,
  input  logic [SCALE_W-1:0] scale_wdata
);

  // per-slot memory entry: period, countdown and user tag
  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(NUM_SLOTS - 1);
  localparam logic [SCALE_W-1:0] MIN_SC    = SCALE_W'(MIN_SCALE);

  // control registers
  state_t               state, state_next;
  logic [SLOT_AW-1:0]   idx, idx_next;
  logic                 pend_valid, pend_valid_next;
  rsp_t                 pend, pend_next;
  logic                 rsp_valid_next;
  rsp_t                 rsp_next;
  logic [SCALE_W-1:0]   prescale, prescale_next;
  logic [DATA_W-1:0]    epoch, epoch_next;
  logic [SCALE_W-1:0]   scale;
  logic [NUM_SLOTS-1:0] slot_active, slot_active_next;
  logic [NUM_SLOTS-1:0] slot_periodic, slot_periodic_next;

  // slot memory, one read and one write port, registered read data
  entry_t               mem [NUM_SLOTS];
  entry_t               rdata;
  logic                 mem_we, mem_re;
  logic [SLOT_AW-1:0]   mem_wa, mem_ra;
  entry_t               mem_wd;

  // datapath helpers
  logic                 accept;
  logic                 out_free;
  logic                 slot_ok;
  logic [SLOT_AW-1:0]   cmd_idx;
  logic [SCALE_W-1:0]   eff_scale;
  logic [SCALE_W-1:0]   prescale_inc;
  logic [DATA_W-1:0]    rem_dec;
  logic                 cur_active;
  logic                 cur_periodic;
  logic                 fire;
  logic                 eval_hold;

  assign cmd_stall    = (state != ST_IDLE);
  assign accept       = cmd_valid && !cmd_stall;
  // output register can take a word this cycle
  assign out_free     = !rsp_valid || !rsp_stall;
  assign slot_ok      = (32'(cmd.slot) < NUM_SLOTS);
  assign cmd_idx      = SLOT_AW'(cmd.slot);
  assign eff_scale    = (scale < MIN_SC) ? MIN_SC : scale;
  assign prescale_inc = prescale + 1'b1;

  // evaluation of the slot whose entry sits in the registered read data
  assign cur_active   = slot_active[idx];
  assign cur_periodic = slot_periodic[idx];
  assign rem_dec      = rdata.remaining - 1'b1;
  assign fire         = cur_active && (rem_dec == '0);
  // a second expiry needs the held one moved out first
  assign eval_hold    = fire && pend_valid && !out_free;

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    pend_valid_next    = pend_valid;
    pend_next          = pend;
    rsp_valid_next     = rsp_valid && rsp_stall;
    rsp_next           = rsp;
    prescale_next      = prescale;
    epoch_next         = epoch;
    slot_active_next   = slot_active;
    slot_periodic_next = slot_periodic;
    mem_we             = 1'b0;
    mem_wa             = idx;
    mem_wd             = rdata;
    mem_re             = 1'b0;
    mem_ra             = idx;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.kind)
            KIND_ARM: begin
              pend_next            = '0;
              pend_next.event_res  = EVENT_STATUS;
              pend_next.status     = (cmd.period == '0) ? STATUS_REFUSED : STATUS_OK;
              pend_valid_next      = 1'b1;
              state_next           = ST_FLUSH;
              if ((cmd.period != '0) && slot_ok) begin
                mem_we                      = 1'b1;
                mem_wa                      = cmd_idx;
                mem_wd.period               = cmd.period;
                mem_wd.remaining            = cmd.period;
                mem_wd.tag                  = cmd.tag;
                slot_active_next[cmd_idx]   = 1'b1;
                slot_periodic_next[cmd_idx] = cmd.periodic;
              end
            end
            KIND_CANCEL: begin
              pend_next           = '0;
              pend_next.event_res = EVENT_STATUS;
              pend_next.status    = STATUS_OK;
              pend_valid_next     = 1'b1;
              state_next          = ST_FLUSH;
              if (slot_ok) begin
                slot_active_next[cmd_idx] = 1'b0;
              end
            end
            KIND_TICK: begin
              prescale_next = prescale_inc;
              if (prescale_inc >= eff_scale) begin
                // scale step: bump epoch and start the slot scan at slot 0
                prescale_next = '0;
                epoch_next    = epoch + 1'b1;
                idx_next      = '0;
                mem_re        = 1'b1;
                mem_ra        = '0;
                state_next    = ST_EVAL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_EVAL: begin
        if (!eval_hold) begin
          if (cur_active) begin
            mem_we           = 1'b1;
            mem_wa           = idx;
            mem_wd           = rdata;
            mem_wd.remaining = (fire && cur_periodic) ? rdata.period : rem_dec;
          end
          if (fire) begin
            // held expiry is not the final one: send it on
            if (pend_valid) begin
              rsp_next       = pend;
              rsp_valid_next = 1'b1;
            end
            pend_next            = '0;
            pend_next.event_res  = EVENT_FIRE;
            pend_next.status     = STATUS_OK;
            pend_next.fired_slot = SLOT_W'(idx);
            pend_next.fired_tag  = rdata.tag;
            pend_next.epoch      = epoch;
            pend_valid_next      = 1'b1;
            if (!cur_periodic) begin
              slot_active_next[idx] = 1'b0;
            end
          end
          if (idx == LAST_SLOT) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
            mem_re   = 1'b1;
            mem_ra   = idx + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          rsp_next        = pend;
          rsp_next.last   = 1'b1;
          rsp_valid_next  = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      pend_valid    <= 1'b0;
      rsp_valid     <= 1'b0;
      prescale      <= '0;
      epoch         <= '0;
      scale         <= SCALE_RESET;
      slot_active   <= '0;
      slot_periodic <= '0;
    end else begin
      state         <= state_next;
      idx           <= idx_next;
      pend_valid    <= pend_valid_next;
      rsp_valid     <= rsp_valid_next;
      prescale      <= prescale_next;
      epoch         <= epoch_next;
      slot_active   <= slot_active_next;
      slot_periodic <= slot_periodic_next;
      if (scale_we) begin
        scale <= scale_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    rsp  <= rsp_next;
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

`ifndef SYNTH
  // no held word may survive into idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("held response left over in idle");

  // arm and cancel always produce a held status word
  a_cmd_status: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.kind == KIND_ARM || cmd.kind == KIND_CANCEL)
    |=> state == ST_FLUSH && pend_valid && pend.event_res == EVENT_STATUS)
    else $error("status word missing after arm or cancel");

  // scan walks the slots one at a time
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL && !eval_hold && idx != LAST_SLOT
    |=> state == ST_EVAL && idx == $past(idx) + 1'b1)
    else $error("slot scan skipped or repeated a slot");

  // a one-shot expiry frees its slot
  a_oneshot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL && fire && !eval_hold && !cur_periodic
    |=> !slot_active[$past(idx)])
    else $error("one-shot slot still active after expiry");

  // a stalled scan keeps its place
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL && eval_hold |=> state == ST_EVAL && $stable(idx))
    else $error("scan moved while output was blocked");
`endif

endmodule

[test/multi_slot_software_timer_core_tb.sv]
// testbench for the multi-slot software timer core: directed and random words vs a predictor
`timescale 1ns / 100ps

module multi_slot_software_timer_core_tb;
  import mst_pkg::*;

  // kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  cmd_t               cmd;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_t               rsp;
  logic               scale_we;
  logic [SCALE_W-1:0] scale_wdata;

  // predictor copy of the slot bank, prescaler, epoch and scale register
  logic                slot_on [NUM_SLOTS];
  logic                slot_repeat [NUM_SLOTS];
  logic [DATA_W-1:0]   slot_reload [NUM_SLOTS];
  logic [DATA_W-1:0]   slot_left [NUM_SLOTS];
  logic [DATA_W-1:0]   slot_user_tag [NUM_SLOTS];
  logic [SCALE_W-1:0]  tick_count;
  logic [DATA_W-1:0]   step_epoch;
  logic [SCALE_W-1:0]  scale_cfg;

  // response words still owed by the block, oldest first
  rsp_t timer_rsp_q[$];

  int mismatch_count = 0;
  // both sides idle at random while this is set
  bit idle_on = 1'b1;

  multi_slot_software_timer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .scale_we    (scale_we),
    .scale_wdata (scale_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // generous watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("multi_slot_software_timer_core_tb failed");
    $finish;
  end

  // receiver stalls at random, about 28 percent of the time, while idling is on
  always @(posedge clk) begin
    rsp_stall <= idle_on && ($urandom_range(0, 99) < 28);
  end

  // first ten failures are shown, the rest only counted
  task automatic note_failure(input string msg);
    if (mismatch_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    end
  endtask

  // every taken response word against the oldest one owed
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (timer_rsp_q.size() == 0) begin
        note_failure($sformatf("response word with none owed: %h", rsp));
      end else begin
        want = timer_rsp_q.pop_front();
        compare_field("event_res", want.event_res, rsp.event_res);
        compare_field("status", want.status, rsp.status);
        compare_field("fired_slot", want.fired_slot, rsp.fired_slot);
        compare_field("fired_tag", want.fired_tag, rsp.fired_tag);
        compare_field("epoch", want.epoch, rsp.epoch);
        compare_field("last", want.last, rsp.last);
      end
    end
  end

  // apply one taken command word to the timer bank and queue the words it owes
  task automatic advance_timers(input cmd_t c);
    rsp_t r;
    rsp_t held;
    bit   have_held;
    int unsigned eff;
    r = '0;
    r.event_res = EVENT_STATUS;
    r.status = STATUS_OK;
    r.last = 1'b1;
    have_held = 1'b0;
    case (c.kind)
      KIND_ARM: begin
        if (c.period == '0) begin
          // refused, slot left as it was
          r.status = STATUS_REFUSED;
        end else begin
          // re-arming an active slot simply replaces its timer
          slot_on[c.slot] = 1'b1;
          slot_repeat[c.slot] = c.periodic;
          slot_reload[c.slot] = c.period;
          slot_left[c.slot] = c.period;
          slot_user_tag[c.slot] = c.tag;
        end
        timer_rsp_q.push_back(r);
      end
      KIND_CANCEL: begin
        slot_on[c.slot] = 1'b0;
        timer_rsp_q.push_back(r);
      end
      KIND_TICK: begin
        // scale of zero acts as the minimum
        eff = (scale_cfg < MIN_SCALE) ? MIN_SCALE : scale_cfg;
        tick_count = tick_count + 1'b1;
        if (tick_count >= eff) begin
          tick_count = '0;
          step_epoch = step_epoch + 1'b1;
          // expiries in slot order, one held back so the final one gets last
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_on[i]) begin
              slot_left[i] = slot_left[i] - 1'b1;
              if (slot_left[i] == '0) begin
                if (have_held) begin
                  timer_rsp_q.push_back(held);
                end
                held = '0;
                held.event_res = EVENT_FIRE;
                held.status = STATUS_OK;
                held.fired_slot = i[SLOT_W-1:0];
                held.fired_tag = slot_user_tag[i];
                held.epoch = step_epoch;
                held.last = 1'b0;
                have_held = 1'b1;
                if (slot_repeat[i]) begin
                  slot_left[i] = slot_reload[i];
                end else begin
                  slot_on[i] = 1'b0;
                end
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            timer_rsp_q.push_back(held);
          end
        end
      end
      default: ;
    endcase
  endtask

  // offer one command word, hold it until taken, then predict it
  task automatic send_word(input cmd_t c);
    while (idle_on && $urandom_range(0, 99) < 28) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    advance_timers(c);
  endtask

  // drop valid, let every owed word arrive, then cover a scan that owes nothing
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (timer_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * NUM_SLOTS + 4) @(posedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] value);
    wait_idle();
    scale_we <= 1'b1;
    scale_wdata <= value;
    @(posedge clk);
    scale_we <= 1'b0;
    scale_cfg = value;
  endtask

  function automatic cmd_t make_word(input logic [1:0] k, input logic [SLOT_W-1:0] s,
                                     input logic [DATA_W-1:0] p, input logic per,
                                     input logic [DATA_W-1:0] t);
    cmd_t c;
    c.kind = k;
    c.slot = s;
    c.period = p;
    c.periodic = per;
    c.tag = t;
    return c;
  endfunction

  // status answers: refusal, idle cancel, ignored kind, replace and cancel of a live slot
  task automatic test_command_answers();
    send_word(make_word(KIND_ARM, 4'd3, '0, 1'b0, 32'h1234_5678));
    send_word(make_word(KIND_CANCEL, 4'd5, $urandom, 1'b1, $urandom));
    send_word(make_word(KIND_UNUSED, 4'd9, $urandom, 1'b1, $urandom));
    send_word(make_word(KIND_ARM, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_word(make_word(KIND_ARM, 4'd15, 32'd2, 1'b0, 32'h0));
    send_word(make_word(KIND_CANCEL, 4'd15, '0, 1'b0, '0));
  endtask

  // every slot expiring on the same step, half of them periodic
  task automatic test_all_slots_fire();
    logic [DATA_W-1:0] t;
    set_scale(16'd1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      t = (i == 0) ? 32'h0 : (i == NUM_SLOTS - 1) ? 32'hFFFF_FFFF : $urandom;
      send_word(make_word(KIND_ARM, i[SLOT_W-1:0], 32'd1, i[0], t));
    end
    send_word(make_word(KIND_TICK, '0, '0, 1'b0, '0));
  endtask

  // largest scale, then lowered under the running count, then zero
  task automatic test_prescaler();
    set_scale(16'hFFFF);
    repeat (3) send_word(make_word(KIND_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    set_scale(16'd2);
    send_word(make_word(KIND_TICK, '0, '0, 1'b0, '0));
    set_scale(16'd0);
    send_word(make_word(KIND_TICK, '0, '0, 1'b0, '0));
  endtask

  function automatic cmd_t random_word();
    cmd_t c;
    int unsigned pick;
    c.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    c.periodic = 1'($urandom_range(0, 1));
    c.tag = $urandom;
    pick = $urandom_range(0, 99);
    c.kind = (pick < 30) ? KIND_ARM : (pick < 40) ? KIND_CANCEL :
             (pick < 95) ? KIND_TICK : KIND_UNUSED;
    // mostly short periods so slots expire, some refused, some full width
    pick = $urandom_range(0, 99);
    c.period = (pick < 10) ? '0 : (pick < 85) ? $urandom_range(1, 6) : $urandom;
    return c;
  endfunction

  // random mix at one scale setting; ignored words do not count
  task automatic test_random_phase(input int count, input logic [SCALE_W-1:0] scale_val,
                                   input bit idling);
    cmd_t c;
    int sent;
    set_scale(scale_val);
    idle_on = idling;
    sent = 0;
    while (sent < count) begin
      c = random_word();
      send_word(c);
      if (c.kind != KIND_UNUSED) begin
        sent++;
      end
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    scale_we = 1'b0;
    scale_wdata = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i] = 1'b0;
      slot_repeat[i] = 1'b0;
      slot_reload[i] = '0;
      slot_left[i] = '0;
      slot_user_tag[i] = '0;
    end
    tick_count = '0;
    step_epoch = '0;
    scale_cfg = SCALE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_command_answers();
    test_all_slots_fire();
    test_prescaler();
    test_random_phase(75, 16'd1, 1'b1);
    test_random_phase(75, 16'd3, 1'b1);
    // a stretch with neither side idling
    test_random_phase(75, 16'd2, 1'b0);
    test_random_phase(75, SCALE_W'($urandom_range(4, 8)), 1'b1);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("multi_slot_software_timer_core_tb passed");
    end else begin
      $display("multi_slot_software_timer_core_tb failed");
    end
    $finish;
  end

endmodule
